### rtl/nh2p_pkg.sv
// shared types, constants and helpers of the 2d histogram peak block
package nh2p_pkg;

	localparam int NBINS      = 32;
	localparam int BIN_W      = $clog2(NBINS);
	localparam int EDGE_DEPTH = NBINS + 1;
	localparam int SLOT_W     = 6;
	localparam int COORD_W    = 24;
	localparam int CNT_W      = 15;
	localparam int ADDR_W     = 2 * BIN_W;
	localparam int RAM_DEPTH  = NBINS * NBINS;
	localparam int Q_DEPTH    = 4;
	localparam int QPTR_W     = $clog2(Q_DEPTH);
	localparam int QCNT_W     = QPTR_W + 1;

	localparam logic [CNT_W-1:0]  CNT_CAP    = '1;
	localparam logic [SLOT_W-1:0] USED_RESET = SLOT_W'(EDGE_DEPTH);

	// item kinds
	localparam logic [2:0] K_WR_X   = 3'd0;
	localparam logic [2:0] K_WR_Y   = 3'd1;
	localparam logic [2:0] K_SAMPLE = 3'd2;
	localparam logic [2:0] K_READ   = 3'd3;
	localparam logic [2:0] K_PEAK   = 3'd4;
	localparam logic [2:0] K_CLEAR  = 3'd5;

	// register indexes
	localparam logic REG_X_USED = 1'b0;
	localparam logic REG_Y_USED = 1'b1;

	// back end operations
	localparam logic [2:0] OP_ZERO   = 3'd0;
	localparam logic [2:0] OP_SAMPLE = 3'd1;
	localparam logic [2:0] OP_READ   = 3'd2;
	localparam logic [2:0] OP_PEAK   = 3'd3;
	localparam logic [2:0] OP_CLEAR  = 3'd4;

	typedef struct packed {
		logic [2:0]       op;
		logic             ok;
		logic [BIN_W-1:0] col;
		logic [BIN_W-1:0] row;
	} qent_t;

	// bins on an axis from the used edge count
	function automatic logic [SLOT_W-1:0] bins_of(input logic [SLOT_W-1:0] used);
		logic [SLOT_W-1:0] u;
		u = (used > USED_RESET) ? USED_RESET : used;
		return (u < SLOT_W'(2)) ? '0 : u - SLOT_W'(1);
	endfunction

endpackage

### rtl/nh2p_ram.sv
// generic single write port ram with registered read
module nh2p_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/nh2p_queue.sv
// small fifo between the classifying front end and the back end
module nh2p_queue import nh2p_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  qent_t             din,
	input  logic              pop,
	output qent_t             head,
	output logic [QCNT_W-1:0] count
);
	qent_t             slot_q [0:Q_DEPTH-1];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;

	assign head = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			count <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			count <= count + QCNT_W'(push) - QCNT_W'(pop);
		end
	end
endmodule

### rtl/nh2p_front.sv
// front end: edge tables, parallel bin location, item classification
module nh2p_front import nh2p_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      take,
	input  logic [2:0]                kind,
	input  logic [SLOT_W-1:0]         edge_slot,
	input  logic signed [COORD_W-1:0] edge_value,
	input  logic signed [COORD_W-1:0] sample_x,
	input  logic signed [COORD_W-1:0] sample_y,
	input  logic [BIN_W-1:0]          read_col,
	input  logic [BIN_W-1:0]          read_row,
	input  logic [SLOT_W-1:0]         nx,
	input  logic [SLOT_W-1:0]         ny,
	output logic                      push,
	output qent_t                     entry,
	output logic [1:0]                pend
);
	logic                      v_s1, v_s2;
	logic [2:0]                kind_s1, kind_s2;
	logic [SLOT_W-1:0]         slot_s1;
	logic signed [COORD_W-1:0] ev_s1, sx_s1, sy_s1;
	logic [BIN_W-1:0]          rc_s1, rr_s1, rc_s2, rr_s2;
	logic                      rok_s2;
	logic [NBINS-1:0]          xm_s2, ym_s2;
	logic                      xlast_s2, ylast_s2;

	logic signed [COORD_W-1:0] xtab_q [0:EDGE_DEPTH-1];
	logic signed [COORD_W-1:0] ytab_q [0:EDGE_DEPTH-1];

	logic [EDGE_DEPTH-1:0] xlt, ylt, xeq, yeq;
	logic [NBINS-1:0]      xm, ym;
	logic [BIN_W-1:0]      xloc, yloc, xfirst, yfirst;
	logic                  xfound, yfound;

	function automatic logic [BIN_W-1:0] first_set(input logic [NBINS-1:0] m);
		logic [BIN_W-1:0] r;
		r = '0;
		for (int k = NBINS - 1; k >= 0; k--) begin
			if (m[k]) r = BIN_W'(k);
		end
		return r;
	endfunction

	assign pend = 2'(v_s1) + 2'(v_s2);

	// edge writes leave from s1, so later samples see them
	always_ff @(posedge clk) begin
		for (int k = 0; k < EDGE_DEPTH; k++) begin
			if (v_s1 && slot_s1 == SLOT_W'(k)) begin
				if (kind_s1 == K_WR_X) xtab_q[k] <= ev_s1;
				if (kind_s1 == K_WR_Y) ytab_q[k] <= ev_s1;
			end
		end
	end

	// one compare lane per edge
	always_comb begin
		for (int k = 0; k < EDGE_DEPTH; k++) begin
			xlt[k] = sx_s1 < xtab_q[k];
			ylt[k] = sy_s1 < ytab_q[k];
			xeq[k] = sx_s1 == xtab_q[k];
			yeq[k] = sy_s1 == ytab_q[k];
		end
		for (int k = 0; k < NBINS; k++) begin
			xm[k] = xlt[k+1] & ~xlt[k] & (SLOT_W'(k) < nx);
			ym[k] = ylt[k+1] & ~ylt[k] & (SLOT_W'(k) < ny);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_s1 <= kind;
			slot_s1 <= edge_slot;
			ev_s1   <= edge_value;
			sx_s1   <= sample_x;
			sy_s1   <= sample_y;
			rc_s1   <= read_col;
			rr_s1   <= read_row;
		end
		kind_s2  <= kind_s1;
		rc_s2    <= rc_s1;
		rr_s2    <= rr_s1;
		rok_s2   <= ({1'b0, rc_s1} < nx) && ({1'b0, rr_s1} < ny);
		xm_s2    <= xm;
		ym_s2    <= ym;
		xlast_s2 <= (nx != '0) && xeq[nx];
		ylast_s2 <= (ny != '0) && yeq[ny];
	end

	// last edge overrides any earlier matching bin
	always_comb begin
		xfirst = first_set(xm_s2);
		yfirst = first_set(ym_s2);
		xloc   = xlast_s2 ? BIN_W'(nx - SLOT_W'(1)) : xfirst;
		yloc   = ylast_s2 ? BIN_W'(ny - SLOT_W'(1)) : yfirst;
		xfound = xlast_s2 | (|xm_s2);
		yfound = ylast_s2 | (|ym_s2);
	end

	always_comb begin
		push      = v_s2;
		entry.op  = OP_ZERO;
		entry.ok  = 1'b0;
		entry.col = '0;
		entry.row = '0;
		case (kind_s2)
			K_SAMPLE: begin
				entry.op  = OP_SAMPLE;
				entry.ok  = xfound & yfound;
				entry.col = xloc;
				entry.row = yloc;
			end
			K_READ: begin
				entry.op  = OP_READ;
				entry.ok  = rok_s2;
				entry.col = rc_s2;
				entry.row = rr_s2;
			end
			K_PEAK:  entry.op = OP_PEAK;
			K_CLEAR: entry.op = OP_CLEAR;
			default: entry.op = OP_ZERO;
		endcase
	end
endmodule

### rtl/nh2p_back.sv
// back end: count store, read-modify-write, peak scan and clearing sweep
module nh2p_back import nh2p_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  qent_t             head,
	input  logic [QCNT_W-1:0] count,
	input  logic [SLOT_W-1:0] nx,
	input  logic [SLOT_W-1:0] ny,
	output logic              pop,
	output logic              init_busy,
	output logic              done,
	output logic              hit,
	output logic [BIN_W-1:0]  bin_col,
	output logic [BIN_W-1:0]  bin_row,
	output logic [CNT_W-1:0]  bin_count
);
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SAMPLE = 3'd1;
	localparam logic [2:0] ST_READ   = 3'd2;
	localparam logic [2:0] ST_PEAK   = 3'd3;
	localparam logic [2:0] ST_CLEAR  = 3'd4;

	logic [2:0]        state_q;
	logic [ADDR_W-1:0] clr_q;
	logic              clr_emit_q;
	logic [BIN_W-1:0]  col_q, row_q;
	logic [BIN_W-1:0]  pc_q, pr_q;
	logic              issue_q, first_q;
	logic              rv_s1, rlast_s1;
	logic [BIN_W-1:0]  rc_s1, rr_s1;
	logic [CNT_W-1:0]  best_q;
	logic [BIN_W-1:0]  bcol_q, brow_q;

	logic              we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [CNT_W-1:0]  wdata, rdata, bumped;
	logic [BIN_W-1:0]  nxm1, nym1;
	logic              take_new, pc_end, pr_end;

	nh2p_ram #(.WIDTH(CNT_W), .DEPTH(RAM_DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign nxm1     = BIN_W'(nx - SLOT_W'(1));
	assign nym1     = BIN_W'(ny - SLOT_W'(1));
	assign pc_end   = pc_q == nxm1;
	assign pr_end   = pr_q == nym1;
	assign bumped   = (rdata == CNT_CAP) ? rdata : rdata + CNT_W'(1);
	assign take_new = first_q || (rdata > best_q);
	assign pop      = (state_q == ST_IDLE) && (count != '0);

	always_comb begin
		we    = 1'b0;
		waddr = {row_q, col_q};
		wdata = bumped;
		raddr = {head.row, head.col};
		case (state_q)
			ST_SAMPLE: we = 1'b1;
			ST_PEAK:   raddr = {pr_q, pc_q};
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			clr_emit_q <= 1'b0;
			init_busy  <= 1'b1;
			done       <= 1'b0;
			hit        <= 1'b0;
			bin_col    <= '0;
			bin_row    <= '0;
			bin_count  <= '0;
			issue_q    <= 1'b0;
			rv_s1      <= 1'b0;
		end else begin
			done  <= 1'b0;
			rv_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						hit       <= 1'b0;
						bin_col   <= '0;
						bin_row   <= '0;
						bin_count <= '0;
						col_q     <= head.col;
						row_q     <= head.row;
						case (head.op)
							OP_SAMPLE: begin
								if (head.ok) state_q <= ST_SAMPLE;
								else done <= 1'b1;
							end
							OP_READ: begin
								if (head.ok) begin
									state_q <= ST_READ;
								end else begin
									done    <= 1'b1;
									bin_col <= head.col;
									bin_row <= head.row;
								end
							end
							OP_PEAK: begin
								if (nx == '0 || ny == '0) begin
									done <= 1'b1;
								end else begin
									state_q <= ST_PEAK;
									pc_q    <= '0;
									pr_q    <= '0;
									issue_q <= 1'b1;
									first_q <= 1'b1;
								end
							end
							OP_CLEAR: begin
								state_q    <= ST_CLEAR;
								clr_q      <= '0;
								clr_emit_q <= 1'b1;
							end
							default: done <= 1'b1;
						endcase
					end
				end
				ST_SAMPLE: begin
					done      <= 1'b1;
					hit       <= 1'b1;
					bin_col   <= col_q;
					bin_row   <= row_q;
					bin_count <= bumped;
					state_q   <= ST_IDLE;
				end
				ST_READ: begin
					done      <= 1'b1;
					bin_col   <= col_q;
					bin_row   <= row_q;
					bin_count <= rdata;
					state_q   <= ST_IDLE;
				end
				ST_PEAK: begin
					// one read issued per cycle, compared when its data returns
					if (issue_q) begin
						rv_s1    <= 1'b1;
						rc_s1    <= pc_q;
						rr_s1    <= pr_q;
						rlast_s1 <= pc_end && pr_end;
						if (pc_end) begin
							pc_q <= '0;
							pr_q <= pr_q + BIN_W'(1);
							if (pr_end) issue_q <= 1'b0;
						end else begin
							pc_q <= pc_q + BIN_W'(1);
						end
					end
					if (rv_s1) begin
						first_q <= 1'b0;
						if (take_new) begin
							best_q <= rdata;
							bcol_q <= rc_s1;
							brow_q <= rr_s1;
						end
						if (rlast_s1) begin
							done      <= 1'b1;
							bin_count <= take_new ? rdata : best_q;
							bin_col   <= take_new ? rc_s1 : bcol_q;
							bin_row   <= take_new ? rr_s1 : brow_q;
							state_q   <= ST_IDLE;
						end
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == '1) begin
						state_q   <= ST_IDLE;
						init_busy <= 1'b0;
						done      <= clr_emit_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### rtl/nonuniform_2d_histogram_peak.sv
// top level of the non-uniform 2d histogram with peak search
//
// usage:
//  - an item is taken on a rising edge with start high and busy low; kind picks
//    the action: write x edge, write y edge, add sample, read bin, find peak,
//    clear counts (other kinds only answer with zeros)
//  - every item gives exactly one result, marked by done for one cycle; the
//    receiver cannot stall, so each result transfer completes in that cycle
//  - x_edges_used / y_edges_used are written through cfg_we, cfg_index and
//    cfg_wdata; the user must write them only while the block is idle,
//    which the block itself does not enforce; both reset to 33, the edge table depth
//  - a front end locates the sample bins with one compare lane per edge; a
//    four entry queue feeds the back end, which owns the count ram
//  - in the back end a counted sample reads the count ram and then writes
//    the count back, while a bin read only reads it; a peak search reads
//    every bin in use (one ram read a cycle), and a clear writes zero to every bin
//  - busy rises when front stages plus queue hold four items
//  - after reset the count ram is swept to zero with busy high;
//    configuration writes are still taken during that sweep
module nonuniform_2d_histogram_peak import nh2p_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [2:0]                kind,
	input  logic [SLOT_W-1:0]         edge_slot,
	input  logic signed [COORD_W-1:0] edge_value,
	input  logic signed [COORD_W-1:0] sample_x,
	input  logic signed [COORD_W-1:0] sample_y,
	input  logic [BIN_W-1:0]          read_col,
	input  logic [BIN_W-1:0]          read_row,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [SLOT_W-1:0]         cfg_wdata,
	output logic                      done,
	output logic                      hit,
	output logic [BIN_W-1:0]          bin_col,
	output logic [BIN_W-1:0]          bin_row,
	output logic [CNT_W-1:0]          bin_count
);
	logic [SLOT_W-1:0] x_used_q, y_used_q;
	logic [SLOT_W-1:0] nx, ny;
	logic              take;
	logic              q_push, q_pop;
	qent_t             q_din, q_head;
	logic [QCNT_W-1:0] q_count;
	logic [1:0]        front_pend;
	logic [QCNT_W-1:0] inflight;
	logic              init_busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_used_q <= USED_RESET;
			y_used_q <= USED_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_X_USED: x_used_q <= cfg_wdata;
				REG_Y_USED: y_used_q <= cfg_wdata;
				default:    x_used_q <= x_used_q;
			endcase
		end
	end

	assign nx = bins_of(x_used_q);
	assign ny = bins_of(y_used_q);

	// items in the front stages hold a queue slot in advance
	assign inflight = QCNT_W'(front_pend) + q_count;
	assign busy     = init_busy || (inflight >= QCNT_W'(Q_DEPTH));
	assign take     = start && !busy;

	nh2p_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.kind       (kind),
		.edge_slot  (edge_slot),
		.edge_value (edge_value),
		.sample_x   (sample_x),
		.sample_y   (sample_y),
		.read_col   (read_col),
		.read_row   (read_row),
		.nx         (nx),
		.ny         (ny),
		.push       (q_push),
		.entry      (q_din),
		.pend       (front_pend)
	);

	nh2p_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.pop    (q_pop),
		.head   (q_head),
		.count  (q_count)
	);

	nh2p_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.count     (q_count),
		.nx        (nx),
		.ny        (ny),
		.pop       (q_pop),
		.init_busy (init_busy),
		.done      (done),
		.hit       (hit),
		.bin_col   (bin_col),
		.bin_row   (bin_row),
		.bin_count (bin_count)
	);

	// queue never pushed while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_count != QCNT_W'(Q_DEPTH)))
		else $error("queue push while full");

	// back end never pops an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (q_count != '0))
		else $error("queue pop while empty");

	// no result while the start-up sweep runs
	a_quiet_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> !done)
		else $error("result during start-up sweep");

	// a counted sample is always reported on a strobe
	a_hit_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		hit && !$stable(hit) |-> done)
		else $error("hit raised without done");
endmodule
